// ===== hdl/temperature_current_anomaly_classifier_core_macros.svh =====
// Assertion macros shared by the classifier core.
`ifndef TEMPERATURE_CURRENT_ANOMALY_CLASSIFIER_CORE_MACROS_SVH
`define TEMPERATURE_CURRENT_ANOMALY_CLASSIFIER_CORE_MACROS_SVH

// The condition must imply the expression in the same cycle.
`define TCAC_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("classifier check failed");

// The condition must imply the expression in the next cycle.
`define TCAC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("classifier check failed");

`endif

// ===== hdl/tcac_pkg.sv =====
// Shared types and constants of the temperature and current anomaly classifier.
package tcac_pkg;

    localparam int TEMP_W      = 12;
    localparam int CUR_W       = 14;
    localparam int DEV_W       = 11;
    localparam int LEVEL_W     = 2;
    localparam int REASON_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 14;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int MIN_HELD    = 10;

    localparam logic signed [TEMP_W-1:0] TEMP_ERROR = -12'sd2032;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CRIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_WARN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_DEV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_CRIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_OVER  = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_OK   = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_CRIT = 2'd2;

    localparam logic [REASON_W-1:0] REASON_NONE      = 3'd0;
    localparam logic [REASON_W-1:0] REASON_TEMP_CRIT = 3'd1;
    localparam logic [REASON_W-1:0] REASON_TEMP_WARN = 3'd2;
    localparam logic [REASON_W-1:0] REASON_TEMP_DEV  = 3'd3;
    localparam logic [REASON_W-1:0] REASON_CUR_CRIT  = 3'd4;
    localparam logic [REASON_W-1:0] REASON_CUR_OVER  = 3'd5;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_crit;
        logic signed [TEMP_W-1:0] temp_warn;
        logic [DEV_W-1:0]         temp_dev;
        logic [CUR_W-1:0]         cur_crit;
        logic [CUR_W-1:0]         cur_over;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic                     temp_ok;
        logic                     temp_crit;
        logic                     temp_warn;
        logic                     cur_crit;
        logic                     cur_over;
    } pre_t;

    typedef struct packed {
        logic idle;
        logic updating;
        logic dividing;
        logic rounding;
        logic finishing;
    } back_stat_t;

endpackage

// ===== hdl/tcac_front.sv =====
// Front end: takes input transfers and runs the checks that need only the limits.
module tcac_front (
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tcac_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  tcac_pkg::cfg_t                  cfg,
    input  logic                            fifo_full,
    output logic                            fifo_push,
    output tcac_pkg::pre_t                  fifo_wdata
);
    import tcac_pkg::*;

    logic signed [TEMP_W-1:0] temp;
    logic [CUR_W-1:0]         cur;

    assign temp = s_axis_tdata[TEMP_W-1:0];
    assign cur  = s_axis_tdata[TEMP_W +: CUR_W];

    assign s_axis_tready = !fifo_full;
    assign fifo_push     = s_axis_tvalid && !fifo_full;

    always_comb
    begin
        fifo_wdata.temp      = temp;
        fifo_wdata.temp_ok   = (temp > $signed(12'sd0)) && (temp != TEMP_ERROR);
        fifo_wdata.temp_crit = temp > $signed(cfg.temp_crit);
        fifo_wdata.temp_warn = temp > $signed(cfg.temp_warn);
        fifo_wdata.cur_crit  = cur > cfg.cur_crit;
        fifo_wdata.cur_over  = cur > cfg.cur_over;
    end

endmodule

// ===== hdl/tcac_fifo.sv =====
// Two-entry queue between the front end and the back end.
module tcac_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcac_pkg::pre_t wdata,
    output logic           full,
    input  logic           pop,
    output tcac_pkg::pre_t rdata,
    output logic           empty
);
    import tcac_pkg::*;

    pre_t       store [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = store[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/tcac_back.sv =====
// Back end: window ring, running total, serial divider, final classification.
module tcac_back #(
    parameter int WINDOW = 60
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fifo_empty,
    input  tcac_pkg::pre_t                   fifo_rdata,
    output logic                             fifo_pop,
    input  tcac_pkg::cfg_t                   cfg,
    output tcac_pkg::back_stat_t             stat,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tcac_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tcac_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TOTAL_W = TEMP_W + SLOT_W;
    localparam int ITER_W  = $clog2(TOTAL_W + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_ROUND  = 6'b010000,
        ST_FINISH = 6'b100000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic [TEMP_W-1:0]        ring [WINDOW];
    logic [WINDOW-1:0]        vld_reg;
    logic [TEMP_W-1:0]        rd_reg;
    logic                     old_vld_reg;
    pre_t                     item_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0]       quo_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic                     neg_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [TEMP_W-1:0] avg_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic signed [TEMP_W-1:0]  old_val;
    logic signed [TOTAL_W-1:0] old_ext;
    logic signed [TOTAL_W-1:0] temp_ext;
    logic [CNT_W:0]            rem_sh;
    logic                      rem_ge;
    logic [CNT_W:0]            rem_sub;
    logic [TEMP_W-1:0]         q_low;
    logic signed [TEMP_W+1:0]  dev_sum;
    logic signed [TEMP_W+1:0]  temp_wide;
    logic                      dev_hit;
    logic [LEVEL_W-1:0]        level;
    logic [REASON_W-1:0]       reason;
    logic                      alert;
    logic                      out_load;

    assign fifo_pop = (state_reg == ST_IDLE) && !fifo_empty;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    assign stat.idle      = state_reg == ST_IDLE;
    assign stat.updating  = state_reg == ST_UPDATE;
    assign stat.dividing  = state_reg == ST_DIV;
    assign stat.rounding  = state_reg == ST_ROUND;
    assign stat.finishing = state_reg == ST_FINISH;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign old_val  = old_vld_reg ? $signed(rd_reg) : '0;
    assign old_ext  = TOTAL_W'(old_val);
    assign temp_ext = TOTAL_W'(item_reg.temp);

    assign rem_sh  = {rem_reg, quo_reg[TOTAL_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, fill_reg};
    assign rem_sub = rem_sh - {1'b0, fill_reg};

    assign q_low = quo_reg[TEMP_W-1:0] + TEMP_W'(neg_reg && (rem_reg != '0));

    assign dev_sum   = (TEMP_W+2)'(avg_reg) + $signed({3'b000, cfg.temp_dev});
    assign temp_wide = (TEMP_W+2)'(item_reg.temp);
    assign dev_hit   = (fill_reg >= CNT_W'(MIN_HELD)) && (temp_wide > dev_sum);

    always_comb
    begin
        level  = LEVEL_OK;
        reason = REASON_NONE;
        if (item_reg.temp_ok)
        begin
            if (item_reg.temp_crit)
            begin
                level  = LEVEL_CRIT;
                reason = REASON_TEMP_CRIT;
            end
            else if (item_reg.temp_warn)
            begin
                level  = LEVEL_WARN;
                reason = REASON_TEMP_WARN;
            end
            else if (dev_hit)
            begin
                level  = LEVEL_WARN;
                reason = REASON_TEMP_DEV;
            end
        end
        if (item_reg.cur_crit)
        begin
            level  = LEVEL_CRIT;
            reason = REASON_CUR_CRIT;
        end
        else if (item_reg.cur_over)
        begin
            if (level == LEVEL_OK)
            begin
                level = LEVEL_WARN;
            end
            reason = REASON_CUR_OVER;
        end
        alert = reason != REASON_NONE;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (iter_reg == ITER_W'(1))
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            old_vld_reg   <= 1'b0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fifo_pop)
            begin
                old_vld_reg <= vld_reg[slot_reg];
            end
            if (state_reg == ST_UPDATE)
            begin
                vld_reg[slot_reg] <= 1'b1;
                total_reg         <= total_reg - old_ext + temp_ext;
                slot_reg          <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                if (fill_reg < CNT_W'(WINDOW))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            ring[slot_reg] <= item_reg.temp;
        end
        if (fifo_pop)
        begin
            rd_reg   <= ring[slot_reg];
            item_reg <= fifo_rdata;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_SETUP:
            begin
                neg_reg  <= total_reg[TOTAL_W-1];
                quo_reg  <= total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : total_reg;
                rem_reg  <= '0;
                iter_reg <= ITER_W'(TOTAL_W);
            end
            ST_DIV:
            begin
                quo_reg  <= {quo_reg[TOTAL_W-2:0], rem_ge};
                rem_reg  <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                iter_reg <= iter_reg - 1'b1;
            end
            ST_ROUND:
            begin
                avg_reg <= neg_reg ? -$signed(q_low) : $signed(q_low);
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_data_reg <= OUT_TDATA_W'({avg_reg, reason, alert, level});
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/temperature_current_anomaly_classifier_core.sv =====
// Flow: an item leaves the queue and passes the back-end states update, setup, divide,
// round and finish, and waits in finish for the output register to drain if needed.
// The back end takes no new item until the last one is through, paced by the bit-serial
// divider that forms the moving average; a two-entry queue takes inputs meanwhile.
// Reset: limits return to their defaults, the ring valid bits clear so every slot
// reads as zero, and fill count, write slot and running total clear; no clearing pass.
`include "temperature_current_anomaly_classifier_core_macros.svh"

module temperature_current_anomaly_classifier_core #(
    parameter int WINDOW = 60
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // temp_sample [11:0], current_sample [25:12], zero pad [31:26]
    input  logic [tcac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level [1:0], alert [2], reason [5:3], temp_average [17:6], zero pad [23:18]
    output logic [tcac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcac_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcac_pkg::*;

    cfg_t       cfg_reg;
    pre_t       push_data;
    pre_t       pop_data;
    logic       fifo_push;
    logic       fifo_pop;
    logic       fifo_full;
    logic       fifo_empty;
    back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_crit <= 12'sd1280;
            cfg_reg.temp_warn <= 12'sd960;
            cfg_reg.temp_dev  <= 11'd160;
            cfg_reg.cur_crit  <= 14'd4500;
            cfg_reg.cur_over  <= 14'd3600;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TEMP_CRIT: cfg_reg.temp_crit <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_WARN: cfg_reg.temp_warn <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_DEV:  cfg_reg.temp_dev  <= cfg_data[DEV_W-1:0];
                CFG_CUR_CRIT:  cfg_reg.cur_crit  <= cfg_data[CUR_W-1:0];
                CFG_CUR_OVER:  cfg_reg.cur_over  <= cfg_data[CUR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tcac_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg           (cfg_reg),
        .fifo_full     (fifo_full),
        .fifo_push     (fifo_push),
        .fifo_wdata    (push_data)
    );

    tcac_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (push_data),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rdata (pop_data),
        .empty (fifo_empty)
    );

    tcac_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (fifo_empty),
        .fifo_rdata    (pop_data),
        .fifo_pop      (fifo_pop),
        .cfg           (cfg_reg),
        .stat          (back_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `TCAC_ASSERT_NEXT(a_pop_starts_update, fifo_pop, back_stat.updating)
    `TCAC_ASSERT_NEXT(a_div_stays_or_rounds, back_stat.dividing,
        back_stat.dividing || back_stat.rounding)
    `TCAC_ASSERT_NEXT(a_finish_returns_idle, back_stat.finishing && m_axis_tready, back_stat.idle)
    `TCAC_ASSERT_SAME(a_cur_crit_is_crit,
        m_axis_tvalid && (m_axis_tdata[5:3] == REASON_CUR_CRIT),
        m_axis_tdata[1:0] == LEVEL_CRIT)

endmodule
